### rtl/gbsp_pkg.sv
// ----------------------------------------------------------------------------
// Grid BFS path finder package
// Shared constants, command codes and controller states.
// ----------------------------------------------------------------------------
package gbsp_pkg;

  // Default grid size.
  localparam int GRID_ROWS_DEF = 13;
  localparam int GRID_COLS_DEF = 24;

  // Fixed port field widths.
  localparam int KIND_W  = 2;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 5;
  localparam int INDEX_W = 9;

  // Command codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Neighbor order used by the search and by the backtrack.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCLR,
    ST_POP,
    ST_POPW,
    ST_NB,
    ST_NBW,
    ST_BT0,
    ST_BT,
    ST_BTW,
    ST_BTS,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_t;

endpackage

### rtl/gbsp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/grid_bfs_shortest_path.sv
// A map write goes straight to the cell memory and returns no result; a read passes through
// ST_RD and ST_RDW, or goes straight to ST_DONE when its index is out of range. A search first
// clears the visited marks, then expands cells from the frontier queue and backtracks the path.
// It takes one transaction at a time and stalls its input until the result is registered.
// After reset the block sweeps every cell of the cell memory to open and accepts no
// transaction until the sweep is done.
// ----------------------------------------------------------------------------
// Grid BFS shortest path
// Breadth-first search over a wall map held in a cell memory, with the
// frontier queue reused as path storage after the backtrack.
// ----------------------------------------------------------------------------
module grid_bfs_shortest_path #(
  parameter int GRID_ROWS = gbsp_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = gbsp_pkg::GRID_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gbsp_pkg::KIND_W-1:0]  in_kind,
  input  logic [gbsp_pkg::ROW_W-1:0]   in_cell_row,
  input  logic [gbsp_pkg::COL_W-1:0]   in_cell_col,
  input  logic                         in_cell_blocked,
  input  logic [gbsp_pkg::ROW_W-1:0]   in_start_row,
  input  logic [gbsp_pkg::COL_W-1:0]   in_start_col,
  input  logic [gbsp_pkg::ROW_W-1:0]   in_goal_row,
  input  logic [gbsp_pkg::COL_W-1:0]   in_goal_col,
  input  logic [gbsp_pkg::INDEX_W-1:0] in_path_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [gbsp_pkg::INDEX_W-1:0] out_path_length,
  output logic [gbsp_pkg::ROW_W-1:0]   out_entry_row,
  output logic [gbsp_pkg::COL_W-1:0]   out_entry_col,
  output logic                         out_entry_valid
);

  localparam int N      = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(N);
  localparam int CNT_W  = $clog2(N + 1);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int CW     = $clog2(GRID_COLS);
  localparam int CELL_W = 2 + 2 * ADDR_W;
  localparam int QW     = RW + CW + ADDR_W;

  // Cell memory address from row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] r,
                                                  input logic [CW-1:0] c);
    cell_addr = ADDR_W'(32'(r) * GRID_COLS + 32'(c));
  endfunction

  gbsp_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt, start_row_r, start_row_nxt;
  logic [RW-1:0]     goal_row_r, goal_row_nxt, best_row_r, best_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt, start_col_r, start_col_nxt;
  logic [CW-1:0]     goal_col_r, goal_col_nxt, best_col_r, best_col_nxt;
  logic [ADDR_W-1:0] cur_dist_r, cur_dist_nxt, len_r, len_nxt;
  logic [ADDR_W-1:0] best_order_r, best_order_nxt;
  logic              best_ok_r, best_ok_nxt, found_r, found_nxt;
  logic [gbsp_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic [RW-1:0]     ent_row_r, ent_row_nxt;
  logic [CW-1:0]     ent_col_r, ent_col_nxt;
  logic              ent_valid_r, ent_valid_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic [gbsp_pkg::INDEX_W-1:0] out_len_r, out_len_nxt;
  logic [gbsp_pkg::ROW_W-1:0]   out_row_r, out_row_nxt;
  logic [gbsp_pkg::COL_W-1:0]   out_col_r, out_col_nxt;
  logic                         out_ev_r, out_ev_nxt;

  // Memory ports.
  logic              cell_we, cell_re, q_we, q_re;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr, q_waddr, q_raddr;
  logic [CELL_W-1:0] cell_wdata, cell_rdata;
  logic [QW-1:0]     q_wdata, q_rdata;

  // Shared decode.
  logic              in_acc, out_free, in_range, path_ok, nb_ok, nb_free, nb_goal;
  logic              is_cand, start_is_goal;
  logic [RW-1:0]     nb_row;
  logic [CW-1:0]     nb_col;
  logic [ADDR_W-1:0] start_addr, want;
  logic              rd_wall, rd_vis;
  logic [ADDR_W-1:0] rd_dist, rd_order;
  logic [RW-1:0]     q_row;
  logic [CW-1:0]     q_col;
  logic [ADDR_W-1:0] q_dist;

  gbsp_ram #(.WIDTH(CELL_W), .DEPTH(N)) u_cell_ram (
    .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .re(cell_re), .raddr(cell_raddr), .rdata(cell_rdata)
  );

  gbsp_ram #(.WIDTH(QW), .DEPTH(N)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // Handshake and field decode.
  assign in_stall  = (state_r != gbsp_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_range  = (32'(in_start_row) < GRID_ROWS) && (32'(in_start_col) < GRID_COLS) &&
                     (32'(in_goal_row) < GRID_ROWS) && (32'(in_goal_col) < GRID_COLS);
  assign path_ok   = found_r && (32'(in_path_index) <= 32'(len_r));
  assign rd_wall   = cell_rdata[CELL_W-1];
  assign rd_vis    = cell_rdata[CELL_W-2];
  assign rd_dist   = cell_rdata[2*ADDR_W-1:ADDR_W];
  assign rd_order  = cell_rdata[ADDR_W-1:0];
  assign q_row     = q_rdata[QW-1 -: RW];
  assign q_col     = q_rdata[ADDR_W+CW-1 -: CW];
  assign q_dist    = q_rdata[ADDR_W-1:0];
  assign start_addr    = cell_addr(start_row_r, start_col_r);
  assign start_is_goal = (start_row_r == goal_row_r) && (start_col_r == goal_col_r);
  assign want      = ADDR_W'(32'(len_r) - 32'(k_r));
  assign nb_free   = !rd_wall && !rd_vis;
  assign nb_goal   = (nb_row == goal_row_r) && (nb_col == goal_col_r);
  assign is_cand   = rd_vis && (rd_dist == want) && (!best_ok_r || rd_order < best_order_r);

  // Neighbor of the current cell in the current direction.
  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (gbsp_pkg::dir_t'(dir_r))
      gbsp_pkg::DIR_LEFT: begin
        nb_ok  = (cur_col_r != '0);
        nb_col = cur_col_r - CW'(1);
      end
      gbsp_pkg::DIR_RIGHT: begin
        nb_ok  = (cur_col_r != CW'(GRID_COLS - 1));
        nb_col = cur_col_r + CW'(1);
      end
      gbsp_pkg::DIR_UP: begin
        nb_ok  = (cur_row_r != '0);
        nb_row = cur_row_r - RW'(1);
      end
      gbsp_pkg::DIR_DOWN: begin
        nb_ok  = (cur_row_r != RW'(GRID_ROWS - 1));
        nb_row = cur_row_r + RW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbsp_pkg::ST_INIT: begin
        if (32'(cnt_r) == N - 1) state_nxt = gbsp_pkg::ST_IDLE;
      end
      gbsp_pkg::ST_IDLE: begin
        if (in_acc && in_kind == gbsp_pkg::KIND_SEARCH) begin
          state_nxt = in_range ? gbsp_pkg::ST_SCLR : gbsp_pkg::ST_DONE;
        end else if (in_acc && in_kind == gbsp_pkg::KIND_READ) begin
          state_nxt = path_ok ? gbsp_pkg::ST_RD : gbsp_pkg::ST_DONE;
        end
      end
      gbsp_pkg::ST_SCLR: begin
        if (32'(cnt_r) == N) begin
          state_nxt = start_is_goal ? gbsp_pkg::ST_DONE : gbsp_pkg::ST_POP;
        end
      end
      gbsp_pkg::ST_POP: begin
        state_nxt = (cnt_r == count_r) ? gbsp_pkg::ST_DONE : gbsp_pkg::ST_POPW;
      end
      gbsp_pkg::ST_POPW: state_nxt = gbsp_pkg::ST_NB;
      gbsp_pkg::ST_NB: begin
        if (nb_ok) state_nxt = gbsp_pkg::ST_NBW;
        else if (dir_r == 2'(gbsp_pkg::DIR_DOWN)) state_nxt = gbsp_pkg::ST_POP;
      end
      gbsp_pkg::ST_NBW: begin
        if (nb_free && nb_goal) state_nxt = gbsp_pkg::ST_BT0;
        else if (dir_r == 2'(gbsp_pkg::DIR_DOWN)) state_nxt = gbsp_pkg::ST_POP;
        else state_nxt = gbsp_pkg::ST_NB;
      end
      gbsp_pkg::ST_BT0: state_nxt = gbsp_pkg::ST_BT;
      gbsp_pkg::ST_BT: begin
        if (nb_ok) state_nxt = gbsp_pkg::ST_BTW;
        else if (dir_r == 2'(gbsp_pkg::DIR_DOWN)) state_nxt = gbsp_pkg::ST_BTS;
      end
      gbsp_pkg::ST_BTW: begin
        state_nxt = (dir_r == 2'(gbsp_pkg::DIR_DOWN)) ? gbsp_pkg::ST_BTS : gbsp_pkg::ST_BT;
      end
      gbsp_pkg::ST_BTS: begin
        state_nxt = (32'(k_r) == 32'(len_r)) ? gbsp_pkg::ST_DONE : gbsp_pkg::ST_BT;
      end
      gbsp_pkg::ST_RD:  state_nxt = gbsp_pkg::ST_RDW;
      gbsp_pkg::ST_RDW: state_nxt = gbsp_pkg::ST_DONE;
      gbsp_pkg::ST_DONE: begin
        if (out_free) state_nxt = gbsp_pkg::ST_IDLE;
      end
      default: state_nxt = gbsp_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result register.
  always_comb begin
    cnt_nxt        = cnt_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    dir_nxt        = dir_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    cur_dist_nxt   = cur_dist_r;
    start_row_nxt  = start_row_r;
    start_col_nxt  = start_col_r;
    goal_row_nxt   = goal_row_r;
    goal_col_nxt   = goal_col_r;
    best_row_nxt   = best_row_r;
    best_col_nxt   = best_col_r;
    best_order_nxt = best_order_r;
    best_ok_nxt    = best_ok_r;
    found_nxt      = found_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    ent_row_nxt    = ent_row_r;
    ent_col_nxt    = ent_col_r;
    ent_valid_nxt  = ent_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_len_nxt    = out_len_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_ev_nxt     = out_ev_r;
    cell_we        = 1'b0;
    cell_waddr     = '0;
    cell_wdata     = '0;
    cell_re        = 1'b0;
    cell_raddr     = cell_addr(nb_row, nb_col);
    q_we           = 1'b0;
    q_waddr        = '0;
    q_wdata        = '0;
    q_re           = 1'b0;
    q_raddr        = cnt_r[ADDR_W-1:0];

    case (state_r)
      // Reset sweep: every cell open.
      gbsp_pkg::ST_INIT: begin
        cell_we    = 1'b1;
        cell_waddr = cnt_r[ADDR_W-1:0];
        cnt_nxt    = cnt_r + CNT_W'(1);
      end
      gbsp_pkg::ST_IDLE: begin
        cnt_nxt       = '0;
        ent_row_nxt   = '0;
        ent_col_nxt   = '0;
        ent_valid_nxt = 1'b0;
        idx_nxt       = in_path_index;
        // Map writes go straight to the cell memory; the other fields are cleared.
        if (in_acc && in_kind == gbsp_pkg::KIND_WRITE &&
            32'(in_cell_row) < GRID_ROWS && 32'(in_cell_col) < GRID_COLS) begin
          cell_we    = 1'b1;
          cell_waddr = cell_addr(RW'(in_cell_row), CW'(in_cell_col));
          cell_wdata = {in_cell_blocked, {(CELL_W-1){1'b0}}};
        end
        if (in_acc && in_kind == gbsp_pkg::KIND_SEARCH) begin
          found_nxt     = 1'b0;
          len_nxt       = '0;
          start_row_nxt = RW'(in_start_row);
          start_col_nxt = CW'(in_start_col);
          goal_row_nxt  = RW'(in_goal_row);
          goal_col_nxt  = CW'(in_goal_col);
        end
      end
      // Clear the visited marks, keeping walls; the start cell is seeded here.
      gbsp_pkg::ST_SCLR: begin
        cell_re    = (32'(cnt_r) != N);
        cell_raddr = cnt_r[ADDR_W-1:0];
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r != '0) begin
          cell_we    = 1'b1;
          cell_waddr = ADDR_W'(cnt_r - CNT_W'(1));
          if (cell_waddr == start_addr) begin
            cell_wdata = {rd_wall, 1'b1, {(2*ADDR_W){1'b0}}};
          end else begin
            cell_wdata = {rd_wall, 1'b0, rd_dist, rd_order};
          end
        end else begin
          q_we    = 1'b1;
          q_waddr = '0;
          q_wdata = {start_row_r, start_col_r, {ADDR_W{1'b0}}};
        end
        if (32'(cnt_r) == N) begin
          cnt_nxt   = '0;
          count_nxt = CNT_W'(1);
          found_nxt = start_is_goal;
        end
      end
      // Take the next cell from the frontier queue.
      gbsp_pkg::ST_POP: begin
        if (cnt_r != count_r) begin
          q_re    = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      gbsp_pkg::ST_POPW: begin
        cur_row_nxt  = q_row;
        cur_col_nxt  = q_col;
        cur_dist_nxt = q_dist;
        dir_nxt      = 2'(gbsp_pkg::DIR_LEFT);
      end
      gbsp_pkg::ST_NB: begin
        cell_re = nb_ok;
        if (!nb_ok) dir_nxt = dir_r + 2'd1;
      end
      // Discover an open, unvisited neighbor.
      gbsp_pkg::ST_NBW: begin
        dir_nxt = dir_r + 2'd1;
        if (nb_free) begin
          cell_we    = 1'b1;
          cell_waddr = cell_addr(nb_row, nb_col);
          cell_wdata = {1'b0, 1'b1, cur_dist_r + ADDR_W'(1), count_r[ADDR_W-1:0]};
          q_we       = 1'b1;
          q_waddr    = count_r[ADDR_W-1:0];
          q_wdata    = {nb_row, nb_col, cur_dist_r + ADDR_W'(1)};
          count_nxt  = count_r + CNT_W'(1);
          if (nb_goal) begin
            found_nxt = 1'b1;
            len_nxt   = cur_dist_r + ADDR_W'(1);
          end
        end
      end
      // Path entry 0 is the goal.
      gbsp_pkg::ST_BT0: begin
        q_we        = 1'b1;
        q_waddr     = '0;
        q_wdata     = {goal_row_r, goal_col_r, {ADDR_W{1'b0}}};
        cur_row_nxt = goal_row_r;
        cur_col_nxt = goal_col_r;
        k_nxt       = CNT_W'(1);
        dir_nxt     = 2'(gbsp_pkg::DIR_LEFT);
        best_ok_nxt = 1'b0;
      end
      gbsp_pkg::ST_BT: begin
        cell_re = nb_ok;
        if (!nb_ok) dir_nxt = dir_r + 2'd1;
      end
      // Keep the earliest-discovered neighbor one step closer to the start.
      gbsp_pkg::ST_BTW: begin
        dir_nxt = dir_r + 2'd1;
        if (is_cand) begin
          best_ok_nxt    = 1'b1;
          best_row_nxt   = nb_row;
          best_col_nxt   = nb_col;
          best_order_nxt = rd_order;
        end
      end
      gbsp_pkg::ST_BTS: begin
        q_we        = 1'b1;
        q_waddr     = k_r[ADDR_W-1:0];
        q_wdata     = {best_row_r, best_col_r, {ADDR_W{1'b0}}};
        cur_row_nxt = best_row_r;
        cur_col_nxt = best_col_r;
        k_nxt       = k_r + CNT_W'(1);
        dir_nxt     = 2'(gbsp_pkg::DIR_LEFT);
        best_ok_nxt = 1'b0;
      end
      gbsp_pkg::ST_RD: begin
        q_re    = 1'b1;
        q_raddr = ADDR_W'(idx_r);
      end
      gbsp_pkg::ST_RDW: begin
        ent_row_nxt   = q_row;
        ent_col_nxt   = q_col;
        ent_valid_nxt = 1'b1;
      end
      // Hand the result to the output register once it is free.
      gbsp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_len_nxt   = gbsp_pkg::INDEX_W'(len_r);
          out_row_nxt   = gbsp_pkg::ROW_W'(ent_row_r);
          out_col_nxt   = gbsp_pkg::COL_W'(ent_col_r);
          out_ev_nxt    = ent_valid_r;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gbsp_pkg::ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      len_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      len_r       <= len_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    count_r      <= count_nxt;
    k_r          <= k_nxt;
    dir_r        <= dir_nxt;
    cur_row_r    <= cur_row_nxt;
    cur_col_r    <= cur_col_nxt;
    cur_dist_r   <= cur_dist_nxt;
    start_row_r  <= start_row_nxt;
    start_col_r  <= start_col_nxt;
    goal_row_r   <= goal_row_nxt;
    goal_col_r   <= goal_col_nxt;
    best_row_r   <= best_row_nxt;
    best_col_r   <= best_col_nxt;
    best_order_r <= best_order_nxt;
    best_ok_r    <= best_ok_nxt;
    idx_r        <= idx_nxt;
    ent_row_r    <= ent_row_nxt;
    ent_col_r    <= ent_col_nxt;
    ent_valid_r  <= ent_valid_nxt;
    out_found_r  <= out_found_nxt;
    out_len_r    <= out_len_nxt;
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_ev_r     <= out_ev_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_path_length = out_len_r;
  assign out_entry_row   = out_row_r;
  assign out_entry_col   = out_col_r;
  assign out_entry_valid = out_ev_r;

endmodule

### rtl/gbsp_checker.sv
// ----------------------------------------------------------------------------
// Grid BFS path finder checker
// Port-level assertions on the input stall and the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gbsp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic [gbsp_pkg::INDEX_W-1:0] out_path_length,
  input logic [gbsp_pkg::ROW_W-1:0]   out_entry_row,
  input logic [gbsp_pkg::COL_W-1:0]   out_entry_col,
  input logic                         out_entry_valid
);

  // The input side is held off right after a reset cycle.
  assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input accepted right after reset");

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A valid path entry exists only after a successful search.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_found)
    else $error("path entry reported without a found path");

  // A failed search reports zero length.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_path_length == '0)
    else $error("nonzero length without a found path");

  // An invalid entry reads as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_entry_row == '0 && out_entry_col == '0)
    else $error("invalid entry carries a cell");

endmodule

bind grid_bfs_shortest_path gbsp_checker u_gbsp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_found(out_found),
  .out_path_length(out_path_length),
  .out_entry_row(out_entry_row),
  .out_entry_col(out_entry_col),
  .out_entry_valid(out_entry_valid)
);
